/* src/hbtm_pkg.sv */
package hbtm_pkg;

    // Table size and time base.
    localparam int NODE_COUNT = 128;
    localparam int TIME_WIDTH = 32;
    localparam int NODE_IDX_W = $clog2(NODE_COUNT);

    // Fixed field widths.
    localparam int OP_W      = 2;
    localparam int NODE_ID_W = 7;
    localparam int PERIOD_W  = 16;
    localparam int COUNT_W   = 8;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd100;
    localparam logic [COUNT_W-1:0]  COUNT_MAX    = 8'hFF;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_TICK      = 2'd0;
    localparam logic [OP_W-1:0] OP_HEARTBEAT = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTART   = 2'd2;

    // One read beat of the check sweep as seen by the accumulator.
    typedef struct packed {
        logic                  start;
        logic                  valid;
        logic [NODE_IDX_W-1:0] idx;
        logic                  expired;
    } check_beat_t;

    // Running summary of a check sweep.
    typedef struct packed {
        logic                 found;
        logic [COUNT_W-1:0]   count;
        logic [NODE_ID_W-1:0] first;
    } check_sum_t;

endpackage

/* src/hbtm_ram.sv */
module hbtm_ram #(
    parameter int DEPTH  = 128,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/hbtm_check_acc.sv */
module hbtm_check_acc (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hbtm_pkg::check_beat_t beat,
    output hbtm_pkg::check_sum_t  sum
);

    logic                           found_reg, found_next;
    logic [hbtm_pkg::COUNT_W-1:0]   count_reg, count_next;
    logic [hbtm_pkg::NODE_ID_W-1:0] first_reg, first_next;

    // Count expired nodes with saturation and keep the lowest one.
    always_comb
    begin
        found_next = found_reg;
        count_next = count_reg;
        first_next = first_reg;
        if (beat.start)
        begin
            found_next = 1'b0;
            count_next = '0;
            first_next = '0;
        end
        else if (beat.valid && beat.expired)
        begin
            found_next = 1'b1;
            if (!found_reg)
            begin
                first_next = hbtm_pkg::NODE_ID_W'(beat.idx);
            end
            if (count_reg != hbtm_pkg::COUNT_MAX)
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
            count_reg <= '0;
            first_reg <= '0;
        end
        else
        begin
            found_reg <= found_next;
            count_reg <= count_next;
            first_reg <= first_next;
        end
    end

    assign sum.found = found_reg;
    assign sum.count = count_reg;
    assign sum.first = first_reg;

endmodule

/* src/heartbeat_timeout_monitor.sv */
// Heartbeat timeout monitor.
// Input channel (in_valid / in_stall) carries operation and node_id: a one
// millisecond tick, a heartbeat from a node, or a restart. Every accepted beat
// produces exactly one result beat on the output channel (out_valid /
// out_stall) with timeout_error, missing_count, first_missing_node,
// check_done and monitoring.
// The configuration channel (cfg_valid / cfg_ready / cfg_data) writes the
// check period; write it only while no item is in flight.
// Heartbeats, plain ticks and unused codes need no sweep: the result is
// registered at the accept edge. A tick that starts a check sweeps the
// last-seen time memory one entry per cycle; the result is registered in
// S_FINISH after the S_CHECK sweep and S_DRAIN. A restart rewrites every
// memory entry with the current time in S_REFRESH, result with the last write.
// One item is processed at a time; the input stalls while a sweep runs or
// while a result waits on a stalled receiver. The output register holds its
// beat unchanged until it is taken.
// After reset the block is monitoring, the clock and period counter are zero,
// no node is recorded and the period is 100 ms. The time memory is not
// cleared; the sweep reads every entry but counts only recorded nodes.
module heartbeat_timeout_monitor (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [hbtm_pkg::OP_W-1:0]      operation,
    input  logic [hbtm_pkg::NODE_ID_W-1:0] node_id,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           timeout_error,
    output logic [hbtm_pkg::COUNT_W-1:0]   missing_count,
    output logic [hbtm_pkg::NODE_ID_W-1:0] first_missing_node,
    output logic                           check_done,
    output logic                           monitoring,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [hbtm_pkg::PERIOD_W-1:0]  cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DRAIN,
        S_FINISH,
        S_REFRESH
    } state_t;

    localparam logic [hbtm_pkg::NODE_IDX_W-1:0] NODE_LAST =
        hbtm_pkg::NODE_IDX_W'(hbtm_pkg::NODE_COUNT - 1);

    state_t                            state_reg, state_next;
    logic [hbtm_pkg::NODE_IDX_W-1:0]   addr_reg, addr_next;
    logic                              rd_valid_reg, rd_valid_next;
    logic [hbtm_pkg::NODE_IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [hbtm_pkg::TIME_WIDTH-1:0]   now_reg, now_next;
    logic [hbtm_pkg::PERIOD_W-1:0]     since_reg, since_next;
    logic                              running_reg, running_next;
    logic [hbtm_pkg::PERIOD_W-1:0]     period_reg, period_next;
    logic [hbtm_pkg::NODE_COUNT-1:0]   recorded_reg, recorded_next;

    logic                              out_valid_reg, out_valid_next;
    logic                              timeout_error_reg, timeout_error_next;
    logic [hbtm_pkg::COUNT_W-1:0]      missing_count_reg, missing_count_next;
    logic [hbtm_pkg::NODE_ID_W-1:0]    first_missing_reg, first_missing_next;
    logic                              check_done_reg, check_done_next;
    logic                              monitoring_reg, monitoring_next;

    logic                              ram_we;
    logic [hbtm_pkg::NODE_IDX_W-1:0]   ram_waddr;
    logic [hbtm_pkg::TIME_WIDTH-1:0]   ram_wdata;
    logic                              ram_re;
    logic [hbtm_pkg::NODE_IDX_W-1:0]   ram_raddr;
    logic [hbtm_pkg::TIME_WIDTH-1:0]   ram_rdata;

    logic                              in_accept;
    logic                              out_free;
    logic [hbtm_pkg::PERIOD_W-1:0]     since_inc;
    logic                              check_hit;
    logic                              node_in_table;
    logic [hbtm_pkg::NODE_IDX_W-1:0]   node_idx;
    logic [hbtm_pkg::TIME_WIDTH-1:0]   age;
    logic                              expired;
    hbtm_pkg::check_beat_t             beat;
    hbtm_pkg::check_sum_t              sum;
    logic                              acc_start;

    // Last-seen time memory.
    hbtm_ram #(
        .DEPTH  (hbtm_pkg::NODE_COUNT),
        .WIDTH  (hbtm_pkg::TIME_WIDTH),
        .ADDR_W (hbtm_pkg::NODE_IDX_W)
    ) u_time_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Age of the entry read in the previous cycle, modulo the clock width.
    assign age     = now_reg - ram_rdata;
    assign expired = recorded_reg[rd_idx_reg] &&
                     (age > hbtm_pkg::TIME_WIDTH'(period_reg));

    assign beat.start   = acc_start;
    assign beat.valid   = rd_valid_reg;
    assign beat.idx     = rd_idx_reg;
    assign beat.expired = expired;

    hbtm_check_acc u_check_acc (
        .clk   (clk),
        .rst_n (rst_n),
        .beat  (beat),
        .sum   (sum)
    );

    // Handshake.
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE) || !out_free;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = (state_reg == S_IDLE);

    assign since_inc     = since_reg + 1'b1;
    assign check_hit     = (since_inc >= period_reg);
    assign node_in_table = (int'(node_id) < hbtm_pkg::NODE_COUNT);
    assign node_idx      = hbtm_pkg::NODE_IDX_W'(node_id);

    // Sequencer: single-cycle items, check sweep and restart sweep.
    always_comb
    begin
        state_next         = state_reg;
        addr_next          = addr_reg;
        now_next           = now_reg;
        since_next         = since_reg;
        running_next       = running_reg;
        period_next        = period_reg;
        recorded_next      = recorded_reg;
        out_valid_next     = out_valid_reg && out_stall;
        timeout_error_next = timeout_error_reg;
        missing_count_next = missing_count_reg;
        first_missing_next = first_missing_reg;
        check_done_next    = check_done_reg;
        monitoring_next    = monitoring_reg;
        ram_we             = 1'b0;
        ram_waddr          = addr_reg;
        ram_wdata          = now_reg;
        ram_re             = 1'b0;
        ram_raddr          = addr_reg;
        acc_start          = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            period_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    // Default result: no check, current running flag.
                    out_valid_next     = 1'b1;
                    timeout_error_next = 1'b0;
                    missing_count_next = '0;
                    first_missing_next = '0;
                    check_done_next    = 1'b0;
                    monitoring_next    = running_reg;
                    case (operation)
                        hbtm_pkg::OP_TICK:
                        begin
                            now_next = now_reg + 1'b1;
                            if (running_reg)
                            begin
                                if (check_hit)
                                begin
                                    since_next     = '0;
                                    acc_start      = 1'b1;
                                    addr_next      = '0;
                                    out_valid_next = 1'b0;
                                    state_next     = S_CHECK;
                                end
                                else
                                begin
                                    since_next = since_inc;
                                end
                            end
                        end
                        hbtm_pkg::OP_HEARTBEAT:
                        begin
                            if (running_reg && node_in_table)
                            begin
                                ram_we                  = 1'b1;
                                ram_waddr               = node_idx;
                                recorded_next[node_idx] = 1'b1;
                            end
                        end
                        hbtm_pkg::OP_RESTART:
                        begin
                            since_next     = '0;
                            running_next   = 1'b1;
                            addr_next      = '0;
                            out_valid_next = 1'b0;
                            state_next     = S_REFRESH;
                        end
                        default:
                        begin
                            // Unused code only reports the running flag.
                        end
                    endcase
                end
            end
            S_CHECK:
            begin
                ram_re    = 1'b1;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == NODE_LAST)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // The last read beat reaches the accumulator here.
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                running_next       = running_reg && !sum.found;
                out_valid_next     = 1'b1;
                timeout_error_next = sum.found;
                missing_count_next = sum.count;
                first_missing_next = sum.first;
                check_done_next    = 1'b1;
                monitoring_next    = running_reg && !sum.found;
                state_next         = S_IDLE;
            end
            S_REFRESH:
            begin
                // Unrecorded entries may take the new time too; they never count as expired.
                ram_we    = 1'b1;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == NODE_LAST)
                begin
                    out_valid_next     = 1'b1;
                    timeout_error_next = 1'b0;
                    missing_count_next = '0;
                    first_missing_next = '0;
                    check_done_next    = 1'b0;
                    monitoring_next    = 1'b1;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        rd_valid_next = ram_re;
        rd_idx_next   = ram_raddr;
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            addr_reg          <= '0;
            rd_valid_reg      <= 1'b0;
            now_reg           <= '0;
            since_reg         <= '0;
            running_reg       <= 1'b1;
            period_reg        <= hbtm_pkg::PERIOD_RESET;
            recorded_reg      <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            addr_reg          <= addr_next;
            rd_valid_reg      <= rd_valid_next;
            now_reg           <= now_next;
            since_reg         <= since_next;
            running_reg       <= running_next;
            period_reg        <= period_next;
            recorded_reg      <= recorded_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        rd_idx_reg        <= rd_idx_next;
        timeout_error_reg <= timeout_error_next;
        missing_count_reg <= missing_count_next;
        first_missing_reg <= first_missing_next;
        check_done_reg    <= check_done_next;
        monitoring_reg    <= monitoring_next;
    end

    assign out_valid          = out_valid_reg;
    assign timeout_error      = timeout_error_reg;
    assign missing_count      = missing_count_reg;
    assign first_missing_node = first_missing_reg;
    assign check_done         = check_done_reg;
    assign monitoring         = monitoring_reg;

    // A reported timeout always stops monitoring.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(timeout_error && monitoring))
        else $error("timeout reported while still monitoring");

    // Error and missing count agree on every result beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (timeout_error == (missing_count != '0)))
        else $error("timeout flag and missing count disagree");

    // Only a check pass may report anything missing.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !check_done) |-> (!timeout_error && first_missing_node == '0))
        else $error("missing node reported without a check");

    // The memory is never read and written in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("time memory read and write overlap");

    // A stalled result beat stays valid until it has been taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("result beat dropped while stalled");

endmodule

/* sim/heartbeat_timeout_monitor_tb.sv */
`timescale 1ns / 100ps

module heartbeat_timeout_monitor_tb;

    import hbtm_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int END_WAIT     = 2 * NODE_COUNT + 20;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 100;
    localparam int REPORT_LINES = 60;

    // Nodes that keep sending heartbeats, so that some checks pass.
    localparam logic [7:0][NODE_ID_W-1:0] STEADY_NODES =
        {7'd0, 7'd5, 7'd42, 7'd64, 7'd127, 7'd1, 7'd85, 7'd126};

    // One result beat, in port order.
    typedef struct packed {
        logic                 timeout_error;
        logic [COUNT_W-1:0]   missing_count;
        logic [NODE_ID_W-1:0] first_missing_node;
        logic                 check_done;
        logic                 monitoring;
    } status_t;

    typedef enum logic {ROW_ITEM, ROW_PERIOD} row_kind_t;

    // One row of the directed sequence; typed rows carry their own status.
    typedef struct packed {
        row_kind_t            kind;
        logic [OP_W-1:0]      op;
        logic [NODE_ID_W-1:0] node;
        logic [PERIOD_W-1:0]  period;
        logic                 typed;
        status_t              want;
    } row_t;

    localparam status_t ST_ON       = '{1'b0, 8'd0, 7'd0, 1'b0, 1'b1};
    localparam status_t ST_OFF      = '{1'b0, 8'd0, 7'd0, 1'b0, 1'b0};
    localparam status_t ST_CHECK_OK = '{1'b0, 8'd0, 7'd0, 1'b1, 1'b1};
    localparam status_t ST_NONE     = '0;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [OP_W-1:0]      operation = OP_TICK;
    logic [NODE_ID_W-1:0] node_id = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 timeout_error;
    logic [COUNT_W-1:0]   missing_count;
    logic [NODE_ID_W-1:0] first_missing_node;
    logic                 check_done;
    logic                 monitoring;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [PERIOD_W-1:0]  cfg_data = '0;

    // Shadow copy of the monitor state.
    logic [TIME_WIDTH-1:0] seen_ms [NODE_COUNT];
    bit [NODE_COUNT-1:0]   node_recorded = '0;
    logic [TIME_WIDTH-1:0] clock_ms = '0;
    logic [PERIOD_W-1:0]   since_ms = '0;
    logic                  run_flag = 1'b1;
    logic [PERIOD_W-1:0]   period_ms = PERIOD_RESET;

    status_t pending_status [$];
    int      mismatches = 0;
    int      results_seen = 0;
    int      cycle_count = 0;
    bit      idle_en = 1'b1;

    // Directed rows: reset default period, period 1 and the largest period, timeouts,
    // stopped monitoring, ignored heartbeats, restart and the age boundary.
    row_t directed_rows [0:24] = '{
        '{ROW_ITEM,   OP_HEARTBEAT, 7'd0,   16'd0,     1'b1, ST_ON},
        '{ROW_ITEM,   OP_HEARTBEAT, 7'd127, 16'd0,     1'b1, ST_ON},
        '{ROW_ITEM,   OP_TICK,      7'd0,   16'd0,     1'b1, ST_ON},
        '{ROW_PERIOD, OP_TICK,      7'd0,   16'd1,     1'b0, ST_NONE},
        '{ROW_ITEM,   OP_TICK,      7'd127, 16'd0,     1'b1,
          '{1'b1, 8'd2, 7'd0, 1'b1, 1'b0}},
        '{ROW_ITEM,   OP_TICK,      7'd0,   16'd0,     1'b1, ST_OFF},
        '{ROW_ITEM,   OP_HEARTBEAT, 7'd85,  16'd0,     1'b1, ST_OFF},
        '{ROW_ITEM,   OP_RESTART,   7'd0,   16'd0,     1'b1, ST_ON},
        '{ROW_ITEM,   OP_TICK,      7'd0,   16'd0,     1'b1, ST_CHECK_OK},
        '{ROW_ITEM,   OP_HEARTBEAT, 7'd42,  16'd0,     1'b1, ST_ON},
        '{ROW_ITEM,   OP_HEARTBEAT, 7'd0,   16'd0,     1'b1, ST_ON},
        '{ROW_ITEM,   OP_TICK,      7'd0,   16'd0,     1'b1,
          '{1'b1, 8'd1, 7'd127, 1'b1, 1'b0}},
        '{ROW_ITEM,   OP_RESTART,   7'd127, 16'd0,     1'b1, ST_ON},
        '{ROW_ITEM,   OP_HEARTBEAT, 7'd85,  16'd0,     1'b1, ST_ON},
        '{ROW_PERIOD, OP_TICK,      7'd0,   16'd65535, 1'b0, ST_NONE},
        '{ROW_ITEM,   OP_TICK,      7'd0,   16'd0,     1'b0, ST_NONE},
        '{ROW_ITEM,   OP_TICK,      7'd85,  16'd0,     1'b0, ST_NONE},
        '{ROW_ITEM,   OP_HEARTBEAT, 7'd127, 16'd0,     1'b0, ST_NONE},
        '{ROW_PERIOD, OP_TICK,      7'd0,   16'd2,     1'b0, ST_NONE},
        '{ROW_ITEM,   OP_TICK,      7'd0,   16'd0,     1'b0, ST_NONE},
        '{ROW_ITEM,   OP_TICK,      7'd0,   16'd0,     1'b0, ST_NONE},
        '{ROW_ITEM,   OP_RESTART,   7'd0,   16'd0,     1'b0, ST_NONE},
        '{ROW_ITEM,   OP_HEARTBEAT, 7'd42,  16'd0,     1'b0, ST_NONE},
        '{ROW_ITEM,   OP_TICK,      7'd0,   16'd0,     1'b0, ST_NONE},
        '{ROW_ITEM,   OP_TICK,      7'd0,   16'd0,     1'b1, ST_CHECK_OK}
    };

    heartbeat_timeout_monitor u_top (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .operation          (operation),
        .node_id            (node_id),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .timeout_error      (timeout_error),
        .missing_count      (missing_count),
        .first_missing_node (first_missing_node),
        .check_done         (check_done),
        .monitoring         (monitoring),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_data           (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Advance the shadow state by one item and return the status it reports.
    function automatic status_t next_status(input logic [OP_W-1:0] op,
                                            input logic [NODE_ID_W-1:0] node);
        status_t               st;
        logic [TIME_WIDTH-1:0] age;
        st = '0;
        if (op == OP_TICK)
        begin
            clock_ms = clock_ms + 1'b1;
            if (run_flag)
            begin
                since_ms = since_ms + 1'b1;
                if (since_ms >= period_ms)
                begin
                    since_ms      = '0;
                    st.check_done = 1'b1;
                    // A node is missing once its age exceeds the period.
                    for (int i = 0; i < NODE_COUNT; i++)
                    begin
                        if (node_recorded[i])
                        begin
                            age = clock_ms - seen_ms[i];
                            if (age > period_ms)
                            begin
                                if (!st.timeout_error)
                                    st.first_missing_node = NODE_ID_W'(i);
                                st.timeout_error = 1'b1;
                                if (st.missing_count != COUNT_MAX)
                                    st.missing_count = st.missing_count + 1'b1;
                            end
                        end
                    end
                    if (st.timeout_error)
                        run_flag = 1'b0;
                end
            end
        end
        else if (op == OP_HEARTBEAT)
        begin
            // Heartbeats are dropped while monitoring is stopped.
            if (run_flag)
            begin
                seen_ms[node]       = clock_ms;
                node_recorded[node] = 1'b1;
            end
        end
        else if (op == OP_RESTART)
        begin
            for (int i = 0; i < NODE_COUNT; i++)
            begin
                if (node_recorded[i])
                    seen_ms[i] = clock_ms;
            end
            since_ms = '0;
            run_flag = 1'b1;
        end
        st.monitoring = run_flag;
        return st;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= REPORT_LINES)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic compare_status(input status_t got, input status_t want, input int idx);
        if (got.timeout_error !== want.timeout_error)
            flag_mismatch($sformatf("result %0d timeout_error got %0b expected %0b",
                                    idx, got.timeout_error, want.timeout_error));
        if (got.missing_count !== want.missing_count)
            flag_mismatch($sformatf("result %0d missing_count got %0d expected %0d",
                                    idx, got.missing_count, want.missing_count));
        if (got.first_missing_node !== want.first_missing_node)
            flag_mismatch($sformatf("result %0d first_missing_node got %0d expected %0d",
                                    idx, got.first_missing_node, want.first_missing_node));
        if (got.check_done !== want.check_done)
            flag_mismatch($sformatf("result %0d check_done got %0b expected %0b",
                                    idx, got.check_done, want.check_done));
        if (got.monitoring !== want.monitoring)
            flag_mismatch($sformatf("result %0d monitoring got %0b expected %0b",
                                    idx, got.monitoring, want.monitoring));
    endtask

    // Drive one input beat, with an optional idle burst in front of it.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [NODE_ID_W-1:0] node,
                             input logic typed, input status_t want);
        int      gap;
        status_t st;
        if (idle_en && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        node_id   <= node;
        do @(posedge clk); while (in_stall);
        st = next_status(op, node);
        pending_status.push_back(typed ? want : st);
    endtask

    // Stop sending and wait until every expected beat has come back.
    task automatic settle_outputs();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_status.size() != 0);
    endtask

    task automatic write_period(input logic [PERIOD_W-1:0] value);
        settle_outputs();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        period_ms = value;
    endtask

    // Random traffic: mostly steady heartbeats and ticks, restarts after a
    // timeout, and some heartbeats from stray nodes or while stopped.
    task automatic run_phase(input int target, input bit full_sweep);
        int                   counted;
        int                   pick;
        int                   stride;
        int                   start;
        logic [OP_W-1:0]      op;
        logic [NODE_ID_W-1:0] node;
        if (full_sweep)
        begin
            // Every node sends once, in a scrambled order.
            if (!run_flag)
                send_item(OP_RESTART, NODE_ID_W'($urandom), 1'b0, ST_NONE);
            stride = 2 * $urandom_range(0, 63) + 1;
            start  = $urandom_range(0, NODE_COUNT - 1);
            for (int k = 0; k < NODE_COUNT; k++)
                send_item(OP_HEARTBEAT, NODE_ID_W'(start + k * stride), 1'b0, ST_NONE);
        end
        counted = 0;
        while (counted < target)
        begin
            pick = $urandom_range(0, 99);
            node = NODE_ID_W'($urandom);
            if (!run_flag)
                op = (pick < 70) ? OP_RESTART : (pick < 90) ? OP_HEARTBEAT : OP_TICK;
            else
                op = (pick < 55) ? OP_TICK : (pick < 93) ? OP_HEARTBEAT : OP_RESTART;
            if (op == OP_HEARTBEAT && $urandom_range(0, 9) != 0)
                node = STEADY_NODES[$urandom_range(0, 7)];
            if (!(op == OP_HEARTBEAT && !run_flag))
                counted++;
            send_item(op, node, 1'b0, ST_NONE);
        end
    endtask

    // Result side: check each beat and stall in random bursts.
    initial
    begin : result_side
        int      stall_left;
        status_t got;
        status_t want;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid === 1'b1 && !out_stall)
            begin
                got = '{timeout_error, missing_count, first_missing_node,
                        check_done, monitoring};
                if (pending_status.size() == 0)
                    flag_mismatch($sformatf("result %0d arrived with nothing expected",
                                            results_seen));
                else
                begin
                    want = pending_status.pop_front();
                    compare_status(got, want, results_seen);
                end
                results_seen++;
            end
            if (stall_left > 0)
                stall_left--;
            else if (idle_en && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 8);
            out_stall <= (stall_left > 0);
        end
    end

    // Cycle counter that ends a hung run.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL heartbeat_timeout_monitor");
        $finish;
    end

    initial
    begin : stimulus
        logic [PERIOD_W-1:0] period_pick;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_PERIOD)
                write_period(directed_rows[r].period);
            else
                send_item(directed_rows[r].op, directed_rows[r].node,
                          directed_rows[r].typed, directed_rows[r].want);
        end

        // Random phases over several periods; the last one runs without idling.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       period_pick = 16'd1;
                1:       period_pick = 16'd3;
                2:       period_pick = PERIOD_RESET;
                3:       period_pick = 16'd65535;
                4:       period_pick = 16'd12;
                5:       period_pick = PERIOD_W'($urandom_range(1, 40));
                6:       period_pick = 16'd2;
                7:       period_pick = 16'd50;
                8:       period_pick = PERIOD_W'($urandom_range(1, 65535));
                default: period_pick = 16'd1;
            endcase
            write_period(period_pick);
            idle_en = (ph != PHASES - 1);
            run_phase(PHASE_ITEMS, ph == 6);
        end

        settle_outputs();
        repeat (END_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("PASS heartbeat_timeout_monitor");
        else
            $display("FAIL heartbeat_timeout_monitor");
        $finish;
    end

endmodule
